FILE: rtl/sws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants of the sliding window sender
// Holds the request/result payload structs, the controller/datapath
// command and status groups, request and register codes.
// ----------------------------------------------------------------------------
package sws_pkg;

	localparam int SEQ_W      = 22;  // segment id width
	localparam int CNT_W      = 23;  // segment count / base width (one past max id)
	localparam int LEN_W      = 11;  // segment length width
	localparam int SEG_SHIFT  = 10;  // log2 of segment size
	localparam int SEG_BYTES  = 1024;
	localparam int TOTAL_W    = 32;
	localparam int WIN_W      = 7;
	localparam int MAX_WINDOW = 64;
	localparam int WIN_RESET  = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// request kinds
	localparam logic [1:0] REQ_START   = 2'd0;
	localparam logic [1:0] REQ_ACK     = 2'd1;
	localparam logic [1:0] REQ_TIMEOUT = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 1'b1;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [SEQ_W-1:0] ack_num;
	} req_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seg_id;
		logic [LEN_W-1:0] seg_len;
		logic             retransmit;
		logic             fin;
		logic             last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_FIN,
		MODE_RESEND,
		MODE_WINDOW
	} mode_t;

	typedef struct packed {
		logic capture;  // take the request into the datapath
		logic eval;     // decide on the request and update window state
		logic emit;     // load one result into the output register
	} cmd_t;

	typedef struct packed {
		logic pending;    // a result is still owed for this request
		logic last;       // the owed result is the final one
		logic slot_free;  // output register can take a result this cycle
	} status_t;

endpackage
`default_nettype wire

FILE: rtl/sws_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_ctrl: sequencer of the sliding window sender
// Accepts one request, lets the datapath evaluate it, then steps out the
// send orders one per free output slot.
// ----------------------------------------------------------------------------
module sws_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire sws_pkg::status_t st,
	output sws_pkg::cmd_t        cmd
);

	sws_pkg::state_t state_q;
	sws_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sws_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sws_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = sws_pkg::ST_EVAL;
			end
			sws_pkg::ST_EVAL: begin
				state_nxt = sws_pkg::ST_EMIT;
			end
			sws_pkg::ST_EMIT: begin
				if (!st.pending) state_nxt = sws_pkg::ST_IDLE;
				else if (st.slot_free && st.last) state_nxt = sws_pkg::ST_IDLE;
			end
			default: state_nxt = sws_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cmd.capture = 1'b0;
		cmd.eval    = 1'b0;
		cmd.emit    = 1'b0;
		unique case (state_q)
			sws_pkg::ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			sws_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
			end
			sws_pkg::ST_EMIT: begin
				cmd.emit = st.pending && st.slot_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/sws_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_datapath: window state, registers and output stage
// Keeps base and next-unsent segment, session flags, the config registers,
// the held request and the result register toward the receiver.
// ----------------------------------------------------------------------------
module sws_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sws_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sws_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire sws_pkg::req_t                     req_data,
	output sws_pkg::res_t                          res_data,
	output logic                                   res_valid,
	input  wire logic                              res_stall,
	input  wire sws_pkg::cmd_t                     cmd,
	output sws_pkg::status_t                       st
);

	localparam int QUOT_W = sws_pkg::TOTAL_W - sws_pkg::SEG_SHIFT;

	logic [sws_pkg::TOTAL_W-1:0] total_q;
	logic [sws_pkg::WIN_W-1:0]   window_q;
	logic [sws_pkg::CNT_W-1:0]   base_q;
	logic [sws_pkg::CNT_W-1:0]   next_q;
	logic                        open_q;
	logic                        finished_q;
	sws_pkg::req_t               req_q;
	sws_pkg::mode_t              mode_q;
	sws_pkg::res_t               res_q;
	logic                        res_valid_q;

	logic [QUOT_W-1:0]           full_segs;
	logic [sws_pkg::CNT_W-1:0]   cnt;
	logic [sws_pkg::WIN_W-1:0]   weff;
	logic [sws_pkg::CNT_W-1:0]   lim;
	logic [sws_pkg::CNT_W-1:0]   ack_ext;
	logic [sws_pkg::CNT_W-1:0]   ack_inc;
	logic [sws_pkg::CNT_W-1:0]   next_inc;
	logic                        more;
	logic                        more_after;
	sws_pkg::mode_t              mode_dec;
	sws_pkg::res_t               res_nxt;

	function automatic logic [sws_pkg::LEN_W-1:0] seg_len_of(
		input logic [sws_pkg::CNT_W-1:0] id,
		input logic [QUOT_W-1:0]         full,
		input logic [sws_pkg::SEG_SHIFT-1:0] rem
	);
		logic [sws_pkg::LEN_W-1:0] len;
		// every segment below the count of full ones is full size
		if (id < {1'b0, full}) len = sws_pkg::LEN_W'(sws_pkg::SEG_BYTES);
		else len = sws_pkg::LEN_W'(rem);
		return len;
	endfunction

	// ceil(total / 1024)
	assign full_segs = total_q[sws_pkg::TOTAL_W-1:sws_pkg::SEG_SHIFT];
	assign cnt = sws_pkg::CNT_W'(full_segs)
		+ sws_pkg::CNT_W'(|total_q[sws_pkg::SEG_SHIFT-1:0]);

	always_comb begin
		if (window_q == '0) weff = sws_pkg::WIN_W'(1);
		else if (window_q > sws_pkg::WIN_W'(sws_pkg::MAX_WINDOW))
			weff = sws_pkg::WIN_W'(sws_pkg::MAX_WINDOW);
		else weff = window_q;
	end

	assign lim        = base_q + sws_pkg::CNT_W'(weff);
	assign ack_ext    = sws_pkg::CNT_W'(req_q.ack_num);
	assign ack_inc    = ack_ext + sws_pkg::CNT_W'(1);
	assign next_inc   = next_q + sws_pkg::CNT_W'(1);
	assign more       = (next_q < lim) && (next_q < cnt);
	assign more_after = (next_inc < lim) && (next_inc < cnt);

	// decision on the held request
	always_comb begin
		mode_dec = sws_pkg::MODE_NONE;
		if (!finished_q) begin
			case (req_q.req_type)
				sws_pkg::REQ_START: begin
					mode_dec = (cnt == '0) ? sws_pkg::MODE_FIN : sws_pkg::MODE_WINDOW;
				end
				sws_pkg::REQ_ACK: begin
					if (open_q && ack_ext >= base_q && ack_ext < cnt) begin
						mode_dec = (ack_inc >= cnt) ? sws_pkg::MODE_FIN
							: sws_pkg::MODE_WINDOW;
					end
				end
				sws_pkg::REQ_TIMEOUT: begin
					if (open_q && base_q < cnt) mode_dec = sws_pkg::MODE_RESEND;
				end
				default: mode_dec = sws_pkg::MODE_NONE;
			endcase
		end
	end

	always_comb begin
		res_nxt.seg_id     = '0;
		res_nxt.seg_len    = '0;
		res_nxt.retransmit = 1'b0;
		res_nxt.fin        = 1'b0;
		res_nxt.last       = 1'b1;
		case (mode_q)
			sws_pkg::MODE_FIN: begin
				res_nxt.fin = 1'b1;
			end
			sws_pkg::MODE_RESEND: begin
				res_nxt.seg_id     = base_q[sws_pkg::SEQ_W-1:0];
				res_nxt.seg_len    = seg_len_of(base_q, full_segs,
					total_q[sws_pkg::SEG_SHIFT-1:0]);
				res_nxt.retransmit = 1'b1;
			end
			sws_pkg::MODE_WINDOW: begin
				res_nxt.seg_id  = next_q[sws_pkg::SEQ_W-1:0];
				res_nxt.seg_len = seg_len_of(next_q, full_segs,
					total_q[sws_pkg::SEG_SHIFT-1:0]);
				res_nxt.last    = !more_after;
			end
			default: begin
				res_nxt.last = 1'b1;
			end
		endcase
	end

	assign st.pending   = (mode_q == sws_pkg::MODE_FIN) || (mode_q == sws_pkg::MODE_RESEND)
		|| ((mode_q == sws_pkg::MODE_WINDOW) && more);
	assign st.last      = res_nxt.last;
	assign st.slot_free = !res_valid_q || !res_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			window_q <= sws_pkg::WIN_W'(sws_pkg::WIN_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sws_pkg::CFG_TOTAL_BYTES: total_q  <= cfg_data;
				sws_pkg::CFG_WINDOW_LEN:  window_q <= cfg_data[sws_pkg::WIN_W-1:0];
				default: total_q <= total_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req_data;
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			next_q     <= '0;
			open_q     <= 1'b0;
			finished_q <= 1'b0;
			mode_q     <= sws_pkg::MODE_NONE;
		end else if (cmd.eval) begin
			mode_q <= mode_dec;
			if (mode_dec == sws_pkg::MODE_FIN) finished_q <= 1'b1;
			if (!finished_q && req_q.req_type == sws_pkg::REQ_START) begin
				open_q <= 1'b1;
				base_q <= '0;
				next_q <= '0;
			end else if (req_q.req_type == sws_pkg::REQ_ACK
				&& (mode_dec == sws_pkg::MODE_FIN || mode_dec == sws_pkg::MODE_WINDOW)) begin
				base_q <= ack_inc;
				// acks past what was sent skip those segments
				if (next_q < ack_inc) next_q <= ack_inc;
			end
		end else if (cmd.emit && mode_q == sws_pkg::MODE_WINDOW) begin
			next_q <= next_inc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) res_q <= res_nxt;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule
`default_nettype wire

FILE: rtl/sliding_window_sender.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_sender: transmit side of a sliding window sender whose timeout resends the base segment
// Turns start, cumulative ack and timeout requests into segment send orders.
// ----------------------------------------------------------------------------
// Usage:
//  - cfg_we/cfg_index/cfg_data write total_bytes (index 0) and the window
//    length (index 1) while the block is idle.
//  - request channel (req_valid/req_stall/req_data) carries start, ack and
//    timeout events; one request is worked on at a time.
//  - result channel (res_valid/res_stall/res_data) carries send orders;
//    the final order of a request has last set.
//  - a request is captured, decided in the EVAL state, then its orders are
//    stepped out in the EMIT state. Throughput is set by the single result
//    register, one order a cycle while the receiver does not stall.
//  - a new request is taken while the final order still waits in the
//    result register.
//  - when the receiver stalls, the order in the result register holds and
//    the sequencer waits; nothing is dropped.
//  - reset clears the session, sets total_bytes to 0 and the window length to 5.
// ----------------------------------------------------------------------------
module sliding_window_sender (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sws_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire sws_pkg::req_t                  req_data,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output sws_pkg::res_t                       res_data
);

	sws_pkg::cmd_t    cmd;
	sws_pkg::status_t st;

	sws_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.st        (st),
		.cmd       (cmd)
	);

	sws_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_data  (req_data),
		.res_data  (res_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
`default_nettype wire
